// ----- src/owtr_pkg.sv -----
`timescale 1ns / 1ps

package owtr_pkg;

    // Default scratchpad length and event queue depth
    localparam int SCRATCH_BYTES_DEF = 9;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

    // One-wire function commands
    localparam logic [7:0] CMD_SKIP_ROM = 8'hcc;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hbe;

    // Raw action codes on the input word
    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_NO_PRES = 3'd1,
        ACT_PRES    = 3'd2,
        ACT_WR_DONE = 3'd3,
        ACT_RD_BIT  = 3'd4
    } t_action;

    // Classified event kinds carried through the queue
    typedef enum logic [2:0] {
        EV_IGNORE   = 3'd0,
        EV_START    = 3'd1,
        EV_NO_PRES  = 3'd2,
        EV_PRES     = 3'd3,
        EV_WR_DONE  = 3'd4,
        EV_RD_BIT   = 3'd5
    } t_ev_kind;

    typedef struct packed {
        t_ev_kind kind;
        logic     bit_val;
    } t_event;

    typedef enum logic [1:0] {
        BUS_NONE  = 2'd0,
        BUS_RESET = 2'd1,
        BUS_WRITE = 2'd2,
        BUS_READ  = 2'd3
    } t_bus_cmd;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_CONVERT    = 5'b00010,
        PH_WAIT       = 5'b00100,
        PH_ISSUE_READ = 5'b01000,
        PH_READ_SP    = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        SUB_RESET  = 3'b001,
        SUB_SKIP   = 3'b010,
        SUB_ACTION = 3'b100
    } t_subphase;

endpackage

// ----- src/owtr_front.sv -----
`timescale 1ns / 1ps

module owtr_front
    import owtr_pkg::*;
(
    input  logic       i_valid,
    input  logic [2:0] i_action,
    input  logic       i_read_value,
    input  logic       i_q_full,
    output logic       o_stall,
    output logic       o_push,
    output t_event     o_event
);

    // Classify the raw action code; undefined codes become no-ops
    always_comb begin
        o_event.bit_val = i_read_value;
        unique case (i_action)
            ACT_START:   o_event.kind = EV_START;
            ACT_NO_PRES: o_event.kind = EV_NO_PRES;
            ACT_PRES:    o_event.kind = EV_PRES;
            ACT_WR_DONE: o_event.kind = EV_WR_DONE;
            ACT_RD_BIT:  o_event.kind = EV_RD_BIT;
            default:     o_event.kind = EV_IGNORE;
        endcase
    end

    // Hold the sender off only while the queue is full
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

// ----- src/owtr_queue.sv -----
`timescale 1ns / 1ps

module owtr_queue
    import owtr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_not_empty,
    output t_event o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_event             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign w_do_pop    = i_pop && o_not_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

endmodule

// ----- src/owtr_back.sv -----
`timescale 1ns / 1ps

module owtr_back
    import owtr_pkg::*;
#(
    parameter int SCRATCH_BYTES = SCRATCH_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_head_valid,
    input  t_event      i_head,
    output logic        o_pop,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [1:0]  o_bus_command,
    output logic        o_write_value,
    output logic        o_report_valid,
    output logic        o_report_error,
    output logic [15:0] o_temperature
);

    localparam int IDX_W = $clog2(SCRATCH_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCRATCH_BYTES - 1);

    t_phase           r_phase, n_phase;
    t_subphase        r_sub, n_sub;
    logic [7:0]       r_shift, n_shift;
    logic [3:0]       r_bit_pos, n_bit_pos;
    logic [IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [7:0]       r_pending, n_pending;
    logic [15:0]      r_wait, n_wait;
    logic [15:0]      r_limit;
    logic [7:0]       r_scratch [SCRATCH_BYTES];
    logic             r_out_valid;
    logic [1:0]       r_cmd;
    logic             r_wv, r_rv, r_err;
    logic [15:0]      r_temp;

    t_bus_cmd    c_cmd;
    logic        c_wv, c_rv, c_err;
    logic [15:0] c_temp;
    logic        w_load, w_sc_we, w_more;
    logic [7:0]  w_new_byte, w_b0, w_b1, w_b6, w_b7;
    logic [15:0] w_word, w_temp;
    logic [16:0] w_wait_inc;
    logic [3:0]  w_bp_inc;

    assign w_load = i_head_valid && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_load;

    // Incoming read bit lands in the MSB of the current byte
    assign w_new_byte = {i_head.bit_val, r_scratch[r_byte_idx][7:1]};
    assign w_more     = (r_bit_pos < 4'd8);
    assign w_wait_inc = {1'b0, r_wait} + 17'd1;
    assign w_bp_inc   = r_bit_pos + 4'd1;

    // Forward the byte being completed into the final computation
    assign w_b0   = (r_byte_idx == IDX_W'(0)) ? w_new_byte : r_scratch[0];
    assign w_b1   = (r_byte_idx == IDX_W'(1)) ? w_new_byte : r_scratch[1];
    assign w_b6   = (r_byte_idx == IDX_W'(6)) ? w_new_byte : r_scratch[6];
    assign w_b7   = (r_byte_idx == IDX_W'(7)) ? w_new_byte : r_scratch[7];
    assign w_word = {w_b1, w_b0};
    assign w_temp = {w_word[12:1], 4'b0000} - 16'd4 + {8'd0, w_b7} - {8'd0, w_b6};

    always_comb begin
        n_phase    = r_phase;
        n_sub      = r_sub;
        n_shift    = r_shift;
        n_bit_pos  = r_bit_pos;
        n_byte_idx = r_byte_idx;
        n_pending  = r_pending;
        n_wait     = r_wait;
        c_cmd      = BUS_NONE;
        c_wv       = 1'b0;
        c_rv       = 1'b0;
        c_err      = 1'b0;
        c_temp     = 16'd0;
        w_sc_we    = 1'b0;
        unique case (i_head.kind)
            EV_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase   = PH_CONVERT;
                    n_pending = CMD_CONVERT;
                    n_sub     = SUB_RESET;
                    c_cmd     = BUS_RESET;
                end
            end
            EV_NO_PRES: begin
                n_phase = PH_IDLE;
                c_rv    = 1'b1;
                c_err   = 1'b1;
            end
            EV_PRES: begin
                n_sub     = SUB_SKIP;
                n_bit_pos = 4'd1;
                n_shift   = CMD_SKIP_ROM;
                c_cmd     = BUS_WRITE;
                c_wv      = CMD_SKIP_ROM[0];
            end
            EV_WR_DONE: begin
                if (r_sub == SUB_SKIP || r_phase == PH_CONVERT
                        || r_phase == PH_ISSUE_READ) begin
                    if (w_more) begin
                        n_shift   = {1'b0, r_shift[7:1]};
                        n_bit_pos = w_bp_inc;
                        c_cmd     = BUS_WRITE;
                        c_wv      = r_shift[1];
                    end else if (r_sub == SUB_SKIP) begin
                        n_sub     = SUB_ACTION;
                        n_bit_pos = 4'd1;
                        n_shift   = r_pending;
                        c_cmd     = BUS_WRITE;
                        c_wv      = r_pending[0];
                    end else if (r_phase == PH_CONVERT) begin
                        n_wait  = 16'd0;
                        n_phase = PH_WAIT;
                        c_cmd   = BUS_READ;
                    end else begin
                        n_phase    = PH_READ_SP;
                        n_bit_pos  = 4'd0;
                        n_byte_idx = '0;
                        c_cmd      = BUS_READ;
                    end
                end
            end
            EV_RD_BIT: begin
                if (r_phase == PH_WAIT) begin
                    if (!i_head.bit_val) begin
                        n_wait = w_wait_inc[15:0];
                        if (w_wait_inc > {1'b0, r_limit}) begin
                            n_phase = PH_IDLE;
                            c_rv    = 1'b1;
                            c_err   = 1'b1;
                        end else begin
                            c_cmd = BUS_READ;
                        end
                    end else begin
                        n_phase   = PH_ISSUE_READ;
                        n_pending = CMD_READ_SP;
                        n_sub     = SUB_RESET;
                        c_cmd     = BUS_RESET;
                    end
                end else if (r_phase == PH_READ_SP) begin
                    w_sc_we = 1'b1;
                    if (w_bp_inc == 4'd8) begin
                        n_bit_pos = 4'd0;
                        if (r_byte_idx == LAST_IDX) begin
                            n_phase = PH_IDLE;
                            c_rv    = 1'b1;
                            c_temp  = w_temp;
                        end else begin
                            n_byte_idx = r_byte_idx + IDX_W'(1);
                            c_cmd      = BUS_READ;
                        end
                    end else begin
                        n_bit_pos = w_bp_inc;
                        c_cmd     = BUS_READ;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_sub       <= SUB_RESET;
            r_shift     <= 8'd0;
            r_bit_pos   <= 4'd0;
            r_byte_idx  <= '0;
            r_pending   <= 8'd0;
            r_wait      <= 16'd0;
            r_limit     <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_load) begin
                r_phase     <= n_phase;
                r_sub       <= n_sub;
                r_shift     <= n_shift;
                r_bit_pos   <= n_bit_pos;
                r_byte_idx  <= n_byte_idx;
                r_pending   <= n_pending;
                r_wait      <= n_wait;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd  <= c_cmd;
            r_wv   <= c_wv;
            r_rv   <= c_rv;
            r_err  <= c_err;
            r_temp <= c_temp;
        end
        if (w_load && w_sc_we) begin
            r_scratch[r_byte_idx] <= w_new_byte;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bus_command  = r_cmd;
    assign o_write_value  = r_wv;
    assign o_report_valid = r_rv;
    assign o_report_error = r_err;
    assign o_temperature  = r_temp;

endmodule

// ----- src/one_wire_temp_read_sequencer_core.sv -----
`timescale 1ns / 1ps
// Accepted words enter the event queue; the sequencer moves them into its output register.
// Throughput: one word per cycle while the queue is not full; the sequencer retires one
// queued event per cycle whenever the output register is empty or being taken.
// Reset (i_rst_n low, synchronous): queue emptied, sequencer idle, timeout limit 10000;
// the scratchpad bytes are not cleared.

module one_wire_temp_read_sequencer_core
    import owtr_pkg::*;
#(
    parameter int SCRATCH_BYTES = SCRATCH_BYTES_DEF,
    parameter int Q_DEPTH       = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: timeout limit
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // event input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic        i_read_value,
    // bus command / report channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_bus_command,
    output logic        o_write_value,
    output logic        o_report_valid,
    output logic        o_report_error,
    output logic [15:0] o_temperature
);

    logic   w_push, w_pop, w_q_full, w_q_not_empty;
    t_event w_event, w_head;

    // Front end: classify the incoming action into an event kind
    owtr_front u_front (
        .i_valid      (i_in_valid),
        .i_action     (i_action),
        .i_read_value (i_read_value),
        .i_q_full     (w_q_full),
        .o_stall      (o_in_stall),
        .o_push       (w_push),
        .o_event      (w_event)
    );

    // Short event queue decouples the input from the sequencer
    owtr_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_event     (w_event),
        .i_pop       (w_pop),
        .o_full      (w_q_full),
        .o_not_empty (w_q_not_empty),
        .o_head      (w_head)
    );

    // Back end: the read sequencer proper, with its registered output word
    owtr_back #(
        .SCRATCH_BYTES (SCRATCH_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_head_valid   (w_q_not_empty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_bus_command  (o_bus_command),
        .o_write_value  (o_write_value),
        .o_report_valid (o_report_valid),
        .o_report_error (o_report_error),
        .o_temperature  (o_temperature)
    );

    // A driven bit only comes with a write slot
    a_wv_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_value) |-> (o_bus_command == BUS_WRITE))
        else $error("write value set without write slot");

    // Reports end the sequence and issue no bus command
    a_report_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_report_valid) |-> (o_bus_command == BUS_NONE))
        else $error("report carries a bus command");

    // Error flag implies a report with zero temperature
    a_err_is_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_report_error) |-> (o_report_valid && o_temperature == 16'd0))
        else $error("malformed error report");

    // On release of reset nothing is pending on either side
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("state not cleared by reset");

endmodule

// ----- sim/tb_one_wire_temp_read_sequencer_core.sv -----
`timescale 1ns / 1ps

module tb_one_wire_temp_read_sequencer_core;
    import owtr_pkg::*;

    localparam int SP_BYTES = SCRATCH_BYTES_DEF;
    localparam int SP_BITS  = SP_BYTES * 8;

    // One bus word as the sequencer puts it out
    typedef struct packed {
        logic [1:0]  cmd;
        logic        wv;
        logic        rpt;
        logic        err;
        logic [15:0] temp;
    } bus_word_t;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [15:0] i_cfg_wdata  = '0;
    logic        i_in_valid   = 1'b0;
    logic [2:0]  i_action     = '0;
    logic        i_read_value = 1'b0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_bus_command;
    logic        o_write_value;
    logic        o_report_valid;
    logic        o_report_error;
    logic [15:0] o_temperature;

    one_wire_temp_read_sequencer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_read_value   (i_read_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bus_command  (o_bus_command),
        .o_write_value  (o_write_value),
        .o_report_valid (o_report_valid),
        .o_report_error (o_report_error),
        .o_temperature  (o_temperature)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the sequencer state, advanced once per accepted input word
    t_phase      seq_phase;
    t_subphase   seq_sub;
    logic [7:0]  tx_byte;
    logic [3:0]  bit_cnt;
    logic [3:0]  byte_idx;
    logic [7:0]  sp_mirror [SP_BYTES];
    logic [7:0]  pend_cmd;
    logic [15:0] poll_cnt;
    logic [15:0] poll_limit;
    // Set once a full scratchpad read has landed; until then bytes in the RTL may still be unknown
    bit          sp_filled;
    bus_word_t   slot_word;

    bus_word_t   expected_bus_words [$];
    int          n_errors;
    int          n_active;
    bit          idle_on   = 1'b1;
    int          noise_pct = 0;
    int          stall_left = 0;

    function automatic void clear_sequencer_mirror();
        seq_phase  = PH_IDLE;
        seq_sub    = SUB_RESET;
        tx_byte    = '0;
        bit_cnt    = '0;
        byte_idx   = '0;
        pend_cmd   = '0;
        poll_cnt   = '0;
        poll_limit = TIMEOUT_RESET;
        sp_filled  = 1'b0;
        for (int i = 0; i < SP_BYTES; i++) sp_mirror[i] = '0;
    endfunction

    // Load a command byte and put its first bit on the bus
    function automatic void load_tx(input logic [7:0] b);
        bit_cnt       = 4'd1;
        tx_byte       = b;
        slot_word.cmd = BUS_WRITE;
        slot_word.wv  = b[0];
    endfunction

    // Put out the next bit; return 0 once the byte is fully sent
    function automatic bit shift_tx();
        if (bit_cnt < 4'd8) begin
            tx_byte       = tx_byte >> 1;
            bit_cnt       = bit_cnt + 4'd1;
            slot_word.cmd = BUS_WRITE;
            slot_word.wv  = tx_byte[0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void flag_error();
        seq_phase     = PH_IDLE;
        slot_word.rpt = 1'b1;
        slot_word.err = 1'b1;
    endfunction

    // Shift one scratchpad bit in, LSB first; report the temperature after the last byte
    function automatic void shift_in(input logic v);
        logic [4:0]  nb;
        logic [15:0] w;
        logic [15:0] t;
        if (byte_idx < SP_BYTES) sp_mirror[byte_idx] = {v, sp_mirror[byte_idx][7:1]};
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt == 4'd8) begin
            bit_cnt  = '0;
            nb       = {1'b0, byte_idx} + 5'd1;
            byte_idx = nb[3:0];
            if (nb == SP_BYTES) begin
                w = {sp_mirror[1], sp_mirror[0]};
                t = {w[15], w[15:1]} << 4;
                t = t - 16'd4 + {8'h00, sp_mirror[7]} - {8'h00, sp_mirror[6]};
                seq_phase      = PH_IDLE;
                sp_filled      = 1'b1;
                slot_word.rpt  = 1'b1;
                slot_word.temp = t;
                return;
            end
        end
        slot_word.cmd = BUS_READ;
    endfunction

    function automatic bus_word_t advance_sequencer(input logic [2:0] act, input logic rv);
        logic [16:0] n;
        slot_word = '0;
        case (act)
            ACT_START: begin
                if (seq_phase == PH_IDLE) begin
                    seq_phase     = PH_CONVERT;
                    pend_cmd      = CMD_CONVERT;
                    seq_sub       = SUB_RESET;
                    slot_word.cmd = BUS_RESET;
                end
            end
            ACT_NO_PRES: flag_error();
            ACT_PRES: begin
                seq_sub = SUB_SKIP;
                load_tx(CMD_SKIP_ROM);
            end
            ACT_WR_DONE: begin
                if (seq_sub == SUB_SKIP) begin
                    if (!shift_tx()) begin
                        seq_sub = SUB_ACTION;
                        load_tx(pend_cmd);
                    end
                end else if (seq_phase == PH_CONVERT) begin
                    if (!shift_tx()) begin
                        poll_cnt      = '0;
                        seq_phase     = PH_WAIT;
                        slot_word.cmd = BUS_READ;
                    end
                end else if (seq_phase == PH_ISSUE_READ) begin
                    if (!shift_tx()) begin
                        seq_phase     = PH_READ_SP;
                        bit_cnt       = '0;
                        byte_idx      = '0;
                        slot_word.cmd = BUS_READ;
                    end
                end
            end
            ACT_RD_BIT: begin
                if (seq_phase == PH_WAIT) begin
                    if (!rv) begin
                        n        = {1'b0, poll_cnt} + 17'd1;
                        poll_cnt = n[15:0];
                        if (n > {1'b0, poll_limit}) flag_error();
                        else slot_word.cmd = BUS_READ;
                    end else begin
                        seq_phase     = PH_ISSUE_READ;
                        pend_cmd      = CMD_READ_SP;
                        seq_sub       = SUB_RESET;
                        slot_word.cmd = BUS_RESET;
                    end
                end else if (seq_phase == PH_READ_SP) begin
                    shift_in(rv);
                end
            end
            default: ;
        endcase
        return slot_word;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one event word, hold it until taken, then log the bus word it should cause
    task automatic send_word(input logic [2:0] act, input logic rv);
        bus_word_t w;
        int        gap;
        // keep a presence pulse out of the first scratchpad read: those bytes are still unknown
        if (act == ACT_PRES && seq_phase == PH_READ_SP && !sp_filled) act = ACT_NO_PRES;
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_read_value <= rv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        w = advance_sequencer(act, rv);
        expected_bus_words.push_back(w);
        if (w.cmd != BUS_NONE || w.rpt) n_active++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop a random event in front of the intended one now and then
    task automatic seq_word(input logic [2:0] act, input logic rv);
        if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
            send_word(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        send_word(act, rv);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_bus_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] lim);
        if (seq_phase != PH_IDLE) send_word(ACT_NO_PRES, 1'b0);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        poll_limit  = lim;
    endtask

    // Whole conversion and scratchpad read; either presence pulse may be replaced by a miss
    task automatic read_sequence(input logic [SP_BITS-1:0] sp, input int unsigned zeros,
                                 input bit lose_first, input bit lose_second);
        int unsigned k;
        seq_word(ACT_START, 1'($urandom_range(0, 1)));
        if (lose_first) begin
            seq_word(ACT_NO_PRES, 1'($urandom_range(0, 1)));
            return;
        end
        seq_word(ACT_PRES, 1'($urandom_range(0, 1)));
        repeat (16) seq_word(ACT_WR_DONE, 1'($urandom_range(0, 1)));
        for (k = 0; k < zeros && seq_phase == PH_WAIT; k++) seq_word(ACT_RD_BIT, 1'b0);
        // timed out or knocked off course: stop here
        if (seq_phase != PH_WAIT) return;
        seq_word(ACT_RD_BIT, 1'b1);
        if (lose_second) begin
            seq_word(ACT_NO_PRES, 1'($urandom_range(0, 1)));
            return;
        end
        seq_word(ACT_PRES, 1'($urandom_range(0, 1)));
        repeat (16) seq_word(ACT_WR_DONE, 1'($urandom_range(0, 1)));
        for (k = 0; k < SP_BITS; k++) seq_word(ACT_RD_BIT, sp[k]);
    endtask

    // Events that do nothing, start while busy, missing presence, presence while idle
    task automatic test_idle_events();
        for (int a = ACT_RD_BIT + 1; a < 8; a++) send_word(3'(a), a[0]);
        send_word(ACT_RD_BIT, 1'b1);
        send_word(ACT_WR_DONE, 1'b0);
        send_word(ACT_START, 1'b0);
        send_word(ACT_START, 1'b1);
        send_word(ACT_NO_PRES, 1'b0);
        send_word(ACT_PRES, 1'b1);
        repeat (17) send_word(ACT_WR_DONE, 1'b0);
        send_word(ACT_NO_PRES, 1'b1);
        drain_results();
    endtask

    // Sign and count extremes of the scratchpad, including wrap of the result
    task automatic test_temperature_extremes();
        logic [15:0]        words [4];
        logic [7:0]         per_c [4];
        logic [7:0]         remain [4];
        logic [SP_BITS-1:0] sp;
        words  = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff};
        per_c  = '{8'h00, 8'hff, 8'h00, 8'h10};
        remain = '{8'h00, 8'h00, 8'hff, 8'h0c};
        for (int i = 0; i < 4; i++) begin
            sp         = SP_BITS'({$urandom, $urandom, $urandom});
            sp[15:0]   = words[i];
            sp[55:48]  = remain[i];
            sp[63:56]  = per_c[i];
            read_sequence(sp, $urandom_range(0, 3), 1'b0, 1'b0);
        end
        drain_results();
    endtask

    // Timeout boundaries: zero limit, one past and exactly at the limit, widest limit
    task automatic test_poll_limits();
        logic [SP_BITS-1:0] sp;
        sp = SP_BITS'({$urandom, $urandom, $urandom});
        write_limit(16'd0);
        read_sequence(sp, 1, 1'b0, 1'b0);
        write_limit(16'd1);
        read_sequence(sp, 2, 1'b0, 1'b0);
        read_sequence(sp, 1, 1'b0, 1'b0);
        write_limit(16'hffff);
        idle_on = 1'b0;
        read_sequence(sp, 5, 1'b0, 1'b0);
        idle_on = 1'b1;
        read_sequence(sp, 3, 1'b0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_sequences();
        logic [15:0]        lim;
        logic [SP_BITS-1:0] sp;
        int unsigned        zeros;
        int                 runs;
        n_active = 0;
        while (n_active < 450) begin
            idle_on   = ($urandom_range(0, 3) != 0);
            noise_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            case ($urandom_range(0, 4))
                0:       lim = 16'($urandom_range(0, 4));
                1:       lim = 16'($urandom_range(5, 40));
                2:       lim = 16'($urandom_range(0, 65535));
                3:       lim = TIMEOUT_RESET;
                default: lim = 16'hffff;
            endcase
            write_limit(lim);
            runs = $urandom_range(1, 3);
            repeat (runs) begin
                sp = SP_BITS'({$urandom, $urandom, $urandom});
                if (lim < 40 && $urandom_range(0, 3) == 0) zeros = lim + 1;
                else zeros = $urandom_range(0, (lim < 12) ? lim : 12);
                read_sequence(sp, zeros, $urandom_range(0, 15) == 0,
                              $urandom_range(0, 15) == 0);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 8))
                        send_word(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
        end
        noise_pct = 0;
        idle_on   = 1'b1;
    endtask

    // Hold the output side back in bursts; one drive per edge
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= pick_stall() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Compare each taken bus word with the oldest one logged
    always @(posedge i_clk) begin : check_out
        bus_word_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bus_words.size() == 0) begin
                $display("%0t: bus word with none expected, actual cmd %0d", $time,
                         o_bus_command);
                n_errors++;
            end else begin
                want = expected_bus_words.pop_front();
                check_field("bus_command", 16'(want.cmd), 16'(o_bus_command));
                check_field("write_value", 16'(want.wv), 16'(o_write_value));
                check_field("report_valid", 16'(want.rpt), 16'(o_report_valid));
                check_field("report_error", 16'(want.err), 16'(o_report_error));
                check_field("temperature", want.temp, o_temperature);
            end
        end
    end

    initial begin
        n_errors = 0;
        clear_sequencer_mirror();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_events();
        test_temperature_extremes();
        test_poll_limits();
        test_random_sequences();
        drain_results();
        if (n_errors == 0 && expected_bus_words.size() == 0)
            $display("[one_wire_temp_read_sequencer_core] OK");
        else
            $display("[one_wire_temp_read_sequencer_core] ERROR");
        $finish;
    end

    // Hard stop well past the slowest passing run
    initial begin
        #(8_000_000);
        $display("[one_wire_temp_read_sequencer_core] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
src/owtr_pkg.sv
src/owtr_front.sv
src/owtr_queue.sv
src/owtr_back.sv
src/one_wire_temp_read_sequencer_core.sv
sim/tb_one_wire_temp_read_sequencer_core.sv
